>>> rtl/rau_pkg.sv
// Package: types, codes and widths for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
  localparam int OperandWidth = 16;
  localparam int DenWidth = OperandWidth - 1;
  localparam int ProdWidth = 2 * OperandWidth;
  localparam int MagWidth = ProdWidth;
  localparam int CountWidth = $clog2(MagWidth + 1);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMBINE,
    ST_GCD_START,
    ST_MOD,
    ST_DIV_START,
    ST_DIV,
    ST_DIV_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    mode_t                           mode;
    logic signed [OperandWidth-1:0]  left_num;
    logic        [DenWidth-1:0]      left_den;
    logic signed [OperandWidth-1:0]  right_num;
    logic        [DenWidth-1:0]      right_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic        [30:0] result_den;
    logic               status;
  } out_t;
endpackage
`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
// Top level: rational arithmetic with Euclidean reduction on one shared divider.
// From acceptance to out_valid: each Euclid step is one setup state and a bit-serial
// remainder; the rest is the product/setup states, two bit-serial divisions and the
// output state. Errors go from the first product state to the output state.
// Throughput: one transaction at a time; in_ready is high only when idle. The result
// register holds until taken. Reset clears the sequencer and the output valid; no memories.
`default_nettype none
module rational_arithmetic_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rau_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rau_pkg::out_t       out_data
);
  localparam int W = rau_pkg::MagWidth;
  localparam int CW = rau_pkg::CountWidth;

  rau_pkg::state_t state, state_next;
  rau_pkg::in_t    op;
  logic signed [W:0] prod_a, prod_b, prod_c;
  logic [W-1:0] den_m, num_m, gcd_a, gcd_b;
  logic [W-1:0] dividend, divisor, rem, quo;
  logic [CW-1:0] cnt;
  logic neg, div_second;
  logic [W-1:0] q_num;

  logic signed [rau_pkg::OperandWidth:0] mul_x, mul_y;
  logic signed [W+1:0] mul_p;
  logic [W:0] rem_sh;
  logic [W:0] rem_try;
  logic bad;

  assign bad = (op.left_den == '0) || (op.right_den == '0) ||
               (op.mode == rau_pkg::MODE_DIV && op.right_num == '0);
  assign mul_p = mul_x * mul_y;
  assign rem_sh = {rem, dividend[W-1]};
  assign rem_try = rem_sh - {1'b0, divisor};
  assign in_ready = (state == rau_pkg::ST_IDLE);

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      rau_pkg::ST_MUL1: begin
        mul_x = (rau_pkg::OperandWidth+1)'(op.left_num);
        unique case (op.mode)
          rau_pkg::MODE_MUL: mul_y = (rau_pkg::OperandWidth+1)'(op.right_num);
          default: mul_y = {2'b00, op.right_den};
        endcase
      end
      rau_pkg::ST_MUL2: begin
        mul_x = {2'b00, op.left_den};
        unique case (op.mode)
          rau_pkg::MODE_DIV: mul_y = (rau_pkg::OperandWidth+1)'(op.right_num);
          rau_pkg::MODE_MUL: mul_y = {2'b00, op.right_den};
          default: mul_y = (rau_pkg::OperandWidth+1)'(op.right_num);
        endcase
      end
      rau_pkg::ST_MUL3: begin
        mul_x = {2'b00, op.left_den};
        mul_y = {2'b00, op.right_den};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::ST_IDLE: if (in_valid) state_next = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1: state_next = bad ? rau_pkg::ST_OUT : rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2: state_next = rau_pkg::ST_MUL3;
      rau_pkg::ST_MUL3: state_next = rau_pkg::ST_COMBINE;
      rau_pkg::ST_COMBINE: state_next = rau_pkg::ST_GCD_START;
      rau_pkg::ST_GCD_START: begin
        if (num_m == '0) state_next = rau_pkg::ST_OUT;
        else if (gcd_b == '0) state_next = rau_pkg::ST_DIV_START;
        else state_next = rau_pkg::ST_MOD;
      end
      rau_pkg::ST_MOD: if (cnt == CW'(1)) state_next = rau_pkg::ST_GCD_START;
      rau_pkg::ST_DIV_START: state_next = rau_pkg::ST_DIV;
      rau_pkg::ST_DIV: if (cnt == CW'(1)) state_next = rau_pkg::ST_DIV_DONE;
      rau_pkg::ST_DIV_DONE:
        state_next = div_second ? rau_pkg::ST_OUT : rau_pkg::ST_DIV_START;
      rau_pkg::ST_OUT: if (!out_valid || out_ready) state_next = rau_pkg::ST_IDLE;
      default: state_next = rau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rau_pkg::ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rau_pkg::ST_IDLE: begin
        if (in_valid) op <= in_data;
        div_second <= 1'b0;
      end
      rau_pkg::ST_MUL1: begin
        prod_a <= mul_p[W:0];
        q_num <= '0;
        den_m <= W'(1);
        neg <= 1'b0;
      end
      rau_pkg::ST_MUL2: prod_b <= mul_p[W:0];
      rau_pkg::ST_MUL3: prod_c <= mul_p[W:0];
      rau_pkg::ST_COMBINE: begin
        logic signed [W:0] n;
        logic [W:0] dd;
        n = '0;
        dd = '0;
        unique case (op.mode)
          rau_pkg::MODE_ADD: n = prod_a + prod_b;
          rau_pkg::MODE_SUB: n = prod_a - prod_b;
          rau_pkg::MODE_MUL: n = prod_a;
          default: n = prod_a;
        endcase
        unique case (op.mode)
          rau_pkg::MODE_MUL: dd = prod_b;
          rau_pkg::MODE_DIV: dd = prod_b[W] ? -prod_b : prod_b;
          default: dd = prod_c;
        endcase
        neg <= n[W] ^ (op.mode == rau_pkg::MODE_DIV && prod_b[W]);
        num_m <= n[W] ? W'(-n) : W'(n);
        den_m <= W'(dd);
        gcd_a <= n[W] ? W'(-n) : W'(n);
        gcd_b <= W'(dd);
      end
      rau_pkg::ST_GCD_START: begin
        dividend <= gcd_a;
        divisor <= gcd_b;
        rem <= '0;
        cnt <= CW'(W);
      end
      rau_pkg::ST_MOD, rau_pkg::ST_DIV: begin
        dividend <= {dividend[W-2:0], 1'b0};
        if (!rem_try[W]) begin
          rem <= rem_try[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (state == rau_pkg::ST_MOD && cnt == CW'(1)) begin
          gcd_a <= gcd_b;
          gcd_b <= !rem_try[W] ? rem_try[W-1:0] : rem_sh[W-1:0];
        end
      end
      rau_pkg::ST_DIV_START: begin
        dividend <= div_second ? den_m : num_m;
        divisor <= gcd_a;
        rem <= '0;
        quo <= '0;
        cnt <= CW'(W);
      end
      rau_pkg::ST_DIV_DONE: begin
        if (div_second) den_m <= quo;
        else q_num <= quo;
        div_second <= 1'b1;
      end
      rau_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_data.status <= bad;
          if (bad || num_m == '0) begin
            out_data.result_num <= '0;
            out_data.result_den <= 31'd1;
          end else begin
            out_data.result_num <= neg ? 32'(-q_num) : 32'(q_num);
            out_data.result_den <= den_m[30:0];
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
